// File: hw/rtl/pthc_pkg.sv
// ----------------------------------------------------------------------------
// pthc_pkg
// Shared types and constants for the pressure/temperature/humidity
// compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pthc_pkg;

   // register indexes
   localparam logic [2:0] REG_TEMP    = 3'd0;
   localparam logic [2:0] REG_PRESS_A = 3'd1;
   localparam logic [2:0] REG_PRESS_B = 3'd2;
   localparam logic [2:0] REG_PRESS_C = 3'd3;
   localparam logic [2:0] REG_HUM     = 3'd4;

   localparam int DivStages = 32;

   // arithmetic shift right of a 32-bit word
   function automatic logic [31:0] asr(input logic [31:0] x, input int n);
      asr = 32'($signed(x) >>> n);
   endfunction

   // 32-bit wrapping product
   function automatic logic [31:0] mul(input logic [31:0] x, input logic [31:0] y);
      mul = 32'(x * y);
   endfunction

   // divider step state
   typedef struct packed {
      logic [31:0] rem;
      logic [31:0] quo;
      logic [31:0] num;
      logic [31:0] den;
   } div_type;

   // payload carried alongside the divider
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
      logic [31:0] hum;
      logic        divz;
      logic        big;
      logic        stale;
   } side_type;

endpackage

`default_nettype wire

// File: hw/rtl/pthc_divider.sv
// ----------------------------------------------------------------------------
// pthc_divider
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage,
// with a side payload and a stall input.
// ----------------------------------------------------------------------------
`default_nettype none

module pthc_divider
   import pthc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire logic     in_valid,
   input  wire logic [31:0] in_num,
   input  wire logic [31:0] in_den,
   input  wire side_type in_side,
   output logic          out_valid,
   output logic [31:0]   out_quo,
   output side_type      out_side
);

   logic     vld_ff [DivStages];
   div_type  st_ff  [DivStages];
   side_type sd_ff  [DivStages];
   div_type  st_in  [DivStages];

   // one quotient bit per stage
   always_comb begin
      div_type    prev;
      logic [32:0] trial;
      for (int i = 0; i < DivStages; i++) begin
         prev = (i == 0) ? div_type'{rem: '0, quo: '0, num: in_num, den: in_den}
                         : st_ff[i-1];
         trial = {prev.rem, prev.num[31]} - {1'b0, prev.den};
         st_in[i].num = {prev.num[30:0], 1'b0};
         st_in[i].den = prev.den;
         if (!trial[32]) begin
            st_in[i].rem = trial[31:0];
            st_in[i].quo = {prev.quo[30:0], 1'b1};
         end else begin
            st_in[i].rem = {prev.rem[30:0], prev.num[31]};
            st_in[i].quo = {prev.quo[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < DivStages; i++) begin
            st_ff[i] <= st_in[i];
            sd_ff[i] <= (i == 0) ? in_side : sd_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DivStages; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < DivStages; i++) vld_ff[i] <= (i == 0) ? in_valid : vld_ff[i-1];
      end
   end

   assign out_valid = vld_ff[DivStages-1];
   assign out_quo   = st_ff[DivStages-1].quo;
   assign out_side  = sd_ff[DivStages-1];

endmodule

`default_nettype wire

// File: hw/rtl/pth_sensor_compensation.sv
// Pipeline: 10 + 32 + 5 = 47 register stages.
// Throughput: one item per cycle unless the output stalls; the 32-stage
// pipelined pressure divider and the multiply stages before and after it
// set the latency.
// The whole pipeline advances only when the output register is free or taken.
// Reset (synchronous) clears all valid bits and the calibration registers.
// ----------------------------------------------------------------------------
// pth_sensor_compensation
// Integer compensation of one raw pressure/temperature/humidity burst.
// ----------------------------------------------------------------------------
`default_nettype none

module pth_sensor_compensation
   import pthc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb, hum_msb, hum_lsb
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // temp_centi, pressure_pa, humidity_q10, press_div_zero, stale, zero pad
   output logic [87:0]      rsp_tdata
);

   localparam int PreStages  = 10;
   localparam int PostStages = 5;

   // calibration registers
   logic [47:0] tc_ff, pa_ff, pb_ff, pc_ff;
   logic [63:0] hc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= '0; pa_ff <= '0; pb_ff <= '0; pc_ff <= '0; hc_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TEMP:    tc_ff <= csr_wdata[47:0];
            REG_PRESS_A: pa_ff <= csr_wdata[47:0];
            REG_PRESS_B: pb_ff <= csr_wdata[47:0];
            REG_PRESS_C: pc_ff <= csr_wdata[47:0];
            REG_HUM:     hc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
   assign t1 = {16'd0, tc_ff[15:0]};
   assign t2 = 32'($signed(tc_ff[31:16]));
   assign t3 = 32'($signed(tc_ff[47:32]));
   assign p1 = {16'd0, pa_ff[15:0]};
   assign p2 = 32'($signed(pa_ff[31:16]));
   assign p3 = 32'($signed(pa_ff[47:32]));
   assign p4 = 32'($signed(pb_ff[15:0]));
   assign p5 = 32'($signed(pb_ff[31:16]));
   assign p6 = 32'($signed(pb_ff[47:32]));
   assign p7 = 32'($signed(pc_ff[15:0]));
   assign p8 = 32'($signed(pc_ff[31:16]));
   assign p9 = 32'($signed(pc_ff[47:32]));
   assign h1 = {24'd0, hc_ff[7:0]};
   assign h2 = 32'($signed(hc_ff[23:8]));
   assign h3 = {24'd0, hc_ff[31:24]};
   assign h4 = 32'($signed(hc_ff[43:32]));
   assign h5 = 32'($signed(hc_ff[55:44]));
   assign h6 = 32'($signed(hc_ff[63:56]));

   // stall control: whole pipe moves when the output slot is free
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // pre-divider pipeline: each stage holds a set of named words
   typedef struct packed {
      logic [31:0] adc_p, adc_t, adc_h;
      logic [31:0] r0, r1, r2, r3, r4, r5, r6, r7;
      logic [31:0] fine, temp, hum;
      logic        stale;
   } pre_type;

   logic    pv_ff [PreStages];
   pre_type ps_ff [PreStages];
   pre_type ps_in [PreStages];

   always_comb begin
      pre_type s;
      for (int i = 0; i < PreStages; i++) begin
         s = (i == 0) ? '0 : ps_ff[i-1];
         unique case (i)
            0: begin
               s.adc_p = {12'd0, req_tdata[7:0], req_tdata[15:8], req_tdata[23:20]};
               s.adc_t = {12'd0, req_tdata[31:24], req_tdata[39:32], req_tdata[47:44]};
               s.adc_h = {16'd0, req_tdata[55:48], req_tdata[63:56]};
               s.stale = (s.adc_t == 32'h80000);
               s.r0 = mul((s.adc_t >> 3) - (t1 << 1), t2);
               s.r1 = (s.adc_t >> 4) - t1;
            end
            1: begin
               s.r0 = asr(s.r0, 11);
               s.r1 = asr(mul(s.r1, s.r1), 12);
            end
            2: begin
               s.r1 = asr(mul(s.r1, t3), 14);
               s.fine = s.r0 + s.r1;
            end
            3: begin
               s.temp = asr(mul(s.fine, 32'd5) + 32'd128, 8);
               s.r0 = asr(s.fine, 1) - 32'd64000;            // a
               s.r1 = mul(asr(s.r0, 2), asr(s.r0, 2));       // sq
               s.r6 = s.fine - 32'd76800;                    // v for humidity
            end
            4: begin
               s.r2 = mul(asr(s.r1, 11), p6);
               s.r3 = mul(s.r0, p5) << 1;
               s.r4 = mul(p3, asr(s.r1, 13));
               s.r5 = asr(mul(p2, s.r0), 1);
               s.r7 = asr(mul(s.r6, h6), 10);
            end
            5: begin
               s.r2 = asr(s.r2 + s.r3, 2) + (p4 << 16);      // b
               s.r4 = asr(asr(s.r4, 3) + s.r5, 18);          // a
               s.r3 = asr(mul(s.r6, h3), 11) + 32'd32768;    // d
               s.r5 = asr(((s.adc_h << 14) - (h4 << 20) - mul(h5, s.r6)) + 32'd16384, 15);
            end
            6: begin
               s.r4 = asr(mul(32'd32768 + s.r4, p1), 15);    // divisor
               s.r7 = asr(mul(s.r7, s.r3), 10) + 32'd2097152;
               s.r2 = mul((32'd1048576 - s.adc_p) - asr(s.r2, 12), 32'd3125);
            end
            7: begin
               s.r7 = asr(mul(s.r7, h2) + 32'd8192, 14);
            end
            8: begin
               s.r6 = mul(s.r5, s.r7);                       // hv
            end
            9: begin
               s.r7 = mul(asr(s.r6, 15), asr(s.r6, 15));
            end
            default: ;
         endcase
         ps_in[i] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < PreStages; i++) ps_ff[i] <= ps_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PreStages; i++) pv_ff[i] <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < PreStages; i++) pv_ff[i] <= (i == 0) ? req_tvalid : pv_ff[i-1];
      end
   end

   // humidity finish and divider launch
   pre_type     lp;
   logic [31:0] hv, hum_w, dnum;
   side_type    dside;
   assign lp = ps_ff[PreStages-1];

   always_comb begin
      hv = lp.r6 - asr(mul(asr(lp.r7, 7), h1), 4);
      if (hv[31])                    hum_w = '0;
      else if (hv > 32'd419430400)   hum_w = 32'd419430400;
      else                           hum_w = hv;
      dside.temp  = lp.temp;
      dside.fine  = lp.fine;
      dside.hum   = hum_w >> 12;
      dside.divz  = (lp.r4 == '0);
      dside.big   = lp.r2[31];
      dside.stale = lp.stale;
      dnum = lp.r2[31] ? lp.r2 : (lp.r2 << 1);
   end

   // pressure divider: the divisor travels with each stage's partial remainder
   logic        dv;
   logic [31:0] dq;
   side_type    ds;

   pthc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (pv_ff[PreStages-1]),
      .in_num    (dnum),
      .in_den    (dside.divz ? 32'd1 : lp.r4),
      .in_side   (dside),
      .out_valid (dv),
      .out_quo   (dq),
      .out_side  (ds)
   );

   // post-divider correction
   typedef struct packed {
      logic [31:0] p, ra, rb;
      side_type    sd;
   } post_type;

   logic     qv_ff [PostStages];
   post_type qs_ff [PostStages];
   post_type qs_in [PostStages];

   always_comb begin
      post_type s;
      for (int i = 0; i < PostStages; i++) begin
         s = (i == 0) ? '0 : qs_ff[i-1];
         unique case (i)
            0: begin
               s.sd = ds;
               s.p  = ds.big ? (dq << 1) : dq;
            end
            1: begin
               s.ra = ((s.p >> 3) * (s.p >> 3)) >> 13;
               s.rb = asr(mul(s.p >> 2, p8), 13);
            end
            2: s.ra = asr(mul(p9, s.ra), 12);
            3: s.p  = s.p + asr(s.ra + s.rb + p7, 4);
            4: if (s.sd.divz) s.p = '0;
            default: ;
         endcase
         qs_in[i] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < PostStages; i++) qs_ff[i] <= qs_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PostStages; i++) qv_ff[i] <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < PostStages; i++) qv_ff[i] <= (i == 0) ? dv : qv_ff[i-1];
      end
   end

   post_type ol;
   assign ol         = qs_ff[PostStages-1];
   assign rsp_tvalid = qv_ff[PostStages-1];
   assign rsp_tdata  = {5'd0, ol.sd.stale, ol.sd.divz, ol.sd.hum[16:0], ol.p, ol.sd.temp};

`ifndef SYNTHESIS
   // a stalled result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // humidity never exceeds the clamp
   a_hum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[80:64] <= 17'd102400)
      else $error("humidity out of range");
   // divide-by-zero forces zero pressure
   a_divz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[81] |-> rsp_tdata[63:32] == 32'd0)
      else $error("pressure not forced to zero");
`endif

endmodule

`default_nettype wire

// File: dv/pth_sensor_compensation_test.sv
// ----------------------------------------------------------------------------
// pth_sensor_compensation_test
// Drives raw measurement bursts through the compensation pipeline under
// several calibration sets and flow-control patterns, and checks every
// result against an integer model of the compensation formulas.
// ----------------------------------------------------------------------------
`default_nettype none

module pth_sensor_compensation_test;
   import pthc_pkg::*;

   // lowest field last, so temp_centi sits in bits 31:0
   typedef struct packed {
      logic        stale;
      logic        press_div_zero;
      logic [16:0] humidity_q10;
      logic [31:0] pressure_pa;
      logic [31:0] temp_centi;
   } comp_result_type;

   // compensation model and queue of expected results
   class comp_scoreboard_type;
      logic [63:0] cal [5];
      comp_result_type pending [$];
      int errors;

      function new();
         foreach (cal[i]) cal[i] = '0;
         errors = 0;
      endfunction

      function void write_cal(logic [2:0] idx, logic [63:0] val);
         if (idx == REG_HUM) cal[idx] = val;
         else if (idx <= REG_PRESS_C) cal[idx] = {16'd0, val[47:0]};
      endfunction

      static function logic [31:0] sra(logic [31:0] x, int n);
         return 32'($signed(x) >>> n);
      endfunction

      static function logic [31:0] sx16(logic [15:0] v);
         return {{16{v[15]}}, v};
      endfunction

      function comp_result_type compensate(logic [63:0] d);
         logic [31:0] adc_p, adc_t, adc_h;
         logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [31:0] h1, h2, h3, h4, h5, h6;
         logic [31:0] a, b, k, fine, p, v;
         comp_result_type r;
         adc_p = {12'd0, d[7:0], d[15:8], d[23:20]};
         adc_t = {12'd0, d[31:24], d[39:32], d[47:44]};
         adc_h = {16'd0, d[55:48], d[63:56]};
         t1 = {16'd0, cal[0][15:0]}; t2 = sx16(cal[0][31:16]); t3 = sx16(cal[0][47:32]);
         p1 = {16'd0, cal[1][15:0]}; p2 = sx16(cal[1][31:16]); p3 = sx16(cal[1][47:32]);
         p4 = sx16(cal[2][15:0]); p5 = sx16(cal[2][31:16]); p6 = sx16(cal[2][47:32]);
         p7 = sx16(cal[3][15:0]); p8 = sx16(cal[3][31:16]); p9 = sx16(cal[3][47:32]);
         h1 = {24'd0, cal[4][7:0]};
         h2 = sx16(cal[4][23:8]);
         h3 = {24'd0, cal[4][31:24]};
         h4 = {{20{cal[4][43]}}, cal[4][43:32]};
         h5 = {{20{cal[4][55]}}, cal[4][55:44]};
         h6 = {{24{cal[4][63]}}, cal[4][63:56]};
         r = '0;
         // temperature
         a = sra(32'(((adc_t >> 3) - (t1 << 1)) * t2), 11);
         k = (adc_t >> 4) - t1;
         b = sra(32'(sra(32'(k * k), 12) * t3), 14);
         fine = a + b;
         r.temp_centi = sra(32'(fine * 5 + 128), 8);
         // pressure
         a = sra(fine, 1) - 32'd64000;
         b = 32'(sra(32'(sra(a, 2) * sra(a, 2)), 11) * p6);
         b = b + 32'(32'(a * p5) << 1);
         b = sra(b, 2) + (p4 << 16);
         a = sra(sra(32'(p3 * sra(32'(sra(a, 2) * sra(a, 2)), 13)), 3)
                 + sra(32'(p2 * a), 1), 18);
         a = sra(32'((32'd32768 + a) * p1), 15);
         if (a == 0) begin
            p = 0;
            r.press_div_zero = 1'b1;
         end else begin
            p = 32'(((32'd1048576 - adc_p) - sra(b, 12)) * 32'd3125);
            if (p < 32'h8000_0000) p = (p << 1) / a;
            else p = (p / a) * 2;
            a = sra(32'(p9 * (32'((p >> 3) * (p >> 3)) >> 13)), 12);
            b = sra(32'((p >> 2) * p8), 13);
            p = p + sra(a + b + p7, 4);
         end
         r.pressure_pa = p;
         // humidity
         v = fine - 32'd76800;
         a = sra(((adc_h << 14) - (h4 << 20) - 32'(h5 * v)) + 32'd16384, 15);
         b = sra(32'(v * h6), 10);
         k = sra(32'(v * h3), 11) + 32'd32768;
         b = sra(32'(b * k), 10) + 32'd2097152;
         b = sra(32'(b * h2) + 32'd8192, 14);
         v = 32'(a * b);
         v = v - sra(32'(sra(32'(sra(v, 15) * sra(v, 15)), 7) * h1), 4);
         if (v[31]) v = 0;
         else if (v > 32'd419430400) v = 32'd419430400;
         r.humidity_q10 = 17'(v >> 12);
         r.stale = (adc_t == 32'h80000);
         return r;
      endfunction

      function void note_burst(logic [63:0] d);
         pending.push_back(compensate(d));
      endfunction

      function void check_result(logic [87:0] d);
         comp_result_type got, exp_r;
         got = d[82:0];
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.temp_centi !== exp_r.temp_centi) begin
            $display("%0t: temp_centi expected %h got %h", $time,
                     exp_r.temp_centi, got.temp_centi);
            errors++;
         end
         if (got.pressure_pa !== exp_r.pressure_pa) begin
            $display("%0t: pressure_pa expected %h got %h", $time,
                     exp_r.pressure_pa, got.pressure_pa);
            errors++;
         end
         if (got.humidity_q10 !== exp_r.humidity_q10) begin
            $display("%0t: humidity_q10 expected %h got %h", $time,
                     exp_r.humidity_q10, got.humidity_q10);
            errors++;
         end
         if (got.press_div_zero !== exp_r.press_div_zero) begin
            $display("%0t: press_div_zero expected %b got %b", $time,
                     exp_r.press_div_zero, got.press_div_zero);
            errors++;
         end
         if (got.stale !== exp_r.stale) begin
            $display("%0t: stale expected %b got %b", $time, exp_r.stale, got.stale);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;

   comp_scoreboard_type sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off = 0;
   int unsigned cycles = 0;

   pth_sensor_compensation u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: sample at rising edge, change ready at falling edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_cal(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // valid stays high between back-to-back items; drain() drops it
   task automatic send_burst(logic [63:0] d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_burst(d);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // typical calibration around a real sensor, with random jitter
   task automatic load_typical();
      write_csr(REG_TEMP, {16'(-1000 + $urandom_range(2000)), 16'(26000 + $urandom_range(600)),
                           16'(27500 + $urandom_range(600))});
      write_csr(REG_PRESS_A, {16'(3024), 16'(-10685), 16'(36000 + $urandom_range(2000))});
      write_csr(REG_PRESS_B, {16'(-7), 16'(-20), 16'(2855)});
      write_csr(REG_PRESS_C, {16'(6000), 16'(-10230), 16'(140)});
      write_csr(REG_HUM, {8'(30), 12'(50), 12'(330), 8'(0), 16'(360), 8'(75)});
   endtask

   task automatic load_random();
      for (int i = 0; i <= REG_HUM; i++)
         write_csr(3'(i), {$urandom, $urandom});
   endtask

   // plausible burst: raw values near the middle of their ranges
   function automatic logic [63:0] typical_burst();
      logic [19:0] rp, rt;
      logic [15:0] rh;
      rp = 20'(330000 + $urandom_range(80000));
      rt = 20'(480000 + $urandom_range(100000));
      rh = 16'(20000 + $urandom_range(30000));
      return {rh[7:0], rh[15:8], rt[3:0], 4'($urandom), rt[11:4], rt[19:12],
              rp[3:0], 4'($urandom), rp[11:4], rp[19:12]};
   endfunction

   function automatic logic [63:0] any_burst();
      return ($urandom_range(3) == 0) ? {$urandom, $urandom} : typical_burst();
   endfunction

   task automatic random_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (n) send_burst(any_burst());
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all-zero calibration: divisor zero everywhere
      send_burst('0);
      send_burst('1);
      drain();

      // directed: extremes, stale marker, low nibbles ignored
      load_typical();
      send_burst('0);
      send_burst('1);
      send_burst({16'h0000, 8'h00, 8'h00, 8'h80, 24'h000000});  // stale
      send_burst({16'hffff, 8'h0f, 8'h00, 8'h80, 24'h0f0000});
      send_burst({16'hffff, 8'hf0, 8'hff, 8'h7f, 24'hf0ffff});
      send_burst({16'h5555, 24'haaaaaa, 24'h555555});
      send_burst({16'haaaa, 24'h555555, 24'haaaaaa});
      repeat (8) send_burst(typical_burst());
      drain();

      // extreme calibration sets
      for (int i = 0; i <= REG_HUM; i++) write_csr(3'(i), '1);
      send_burst('0);
      send_burst('1);
      send_burst(typical_burst());
      drain();
      for (int i = 0; i <= REG_HUM; i++) write_csr(3'(i), 64'h8000_8000_8000_8000);
      send_burst('0);
      send_burst(typical_burst());
      drain();
      write_csr(3'd7, '1);  // out-of-range index, ignored

      load_typical();
      random_phase(200, 0, 0);
      random_phase(200, 78, 0);
      load_random();
      random_phase(100, 0, 78);
      load_typical();
      random_phase(200, 0, 78);
      random_phase(150, 20, 20);

      // back-pressure: receiver holds off while bursts keep coming
      hold_off = 300;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (120) send_burst(any_burst());
      drain();

      load_random();
      random_phase(150, 0, 0);

      if (sb.errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
